@@ design/rsp_pkg.sv @@
// Shared types, constants and saturation helpers for the rotation speed profiler.
// Used by rsp_ctrl, rsp_datapath and rotation_speed_profile_unit; no dependencies.
package rsp_pkg;

    // Quotient bits produced by the stopping-angle divider.
    localparam int unsigned DIV_STEPS = 31;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    // Heading wrap limits in Q16.16.
    localparam logic signed [20:0] PI_Q     = 21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q = 21'sd411775;

    // Register reset values.
    localparam logic [30:0] ACCEL_RST = 31'd65536;
    localparam logic [30:0] SPEED_RST = 31'd196608;
    localparam logic [30:0] FLOOR_RST = 31'd6554;
    localparam logic [17:0] TOL_RST   = 18'd1311;

    // Register indexes.
    localparam logic [1:0] CFG_ACCEL = 2'd0;
    localparam logic [1:0] CFG_SPEED = 2'd1;
    localparam logic [1:0] CFG_FLOOR = 2'd2;
    localparam logic [1:0] CFG_TOL   = 2'd3;

    typedef enum logic [1:0] {
        PH_ACC    = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DINIT, S_DSTEP, S_LHS, S_PH, S_CRS, S_BMUL, S_BCMP, S_DEC, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_SET_TARGET, CMD_LOAD, CMD_MUL, CMD_DIV_INIT, CMD_DIV_STEP,
        CMD_LHS, CMD_ACC, CMD_CRUISE, CMD_BMUL, CMD_DEC, CMD_OUT
    } t_op;

    typedef struct packed {
        t_op    op;
        t_phase phase;
    } t_cmd;

    typedef struct packed {
        logic acc_lim;
        logic div_sat;
        logic brake;
        logic out_busy;
    } t_status;

    // Saturate a 34-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [31:0] res;
        if (x > 34'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < $signed(34'h3_8000_0000)) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    // Apply a sign to a magnitude and saturate to the signed 32-bit range.
    function automatic logic signed [31:0] mag_to_s32(input logic neg, input logic [32:0] q);
        logic signed [31:0] res;
        if (!neg) begin
            res = (q > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
        end else begin
            res = (q > 33'h0_8000_0000) ? 32'sh8000_0000 : $signed(-q[31:0]);
        end
        return res;
    endfunction

endpackage

@@ design/rsp_ctrl.sv @@
// Sequencing state machine of the rotation speed profiler: holds the phase and issues
// at most one datapath command per cycle, none while output waits. Depends on rsp_pkg.
module rsp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_action,
    output logic              o_in_ready,
    input  rsp_pkg::t_status  i_status,
    output rsp_pkg::t_cmd     o_cmd
);
    import rsp_pkg::*;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_crs_done, n_crs_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_ACC;
            r_cnt      <= '0;
            r_crs_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_crs_done <= n_crs_done;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_crs_done = r_crs_done;
        o_in_ready = 1'b0;
        o_cmd.op   = CMD_NONE;
        o_cmd.phase = r_phase;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_in_action) begin
                        o_cmd.op = CMD_SET_TARGET;
                        n_phase  = PH_ACC;
                    end else begin
                        o_cmd.op = CMD_LOAD;
                        n_state  = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.op = CMD_MUL;
                n_state  = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.op = CMD_DIV_INIT;
                n_cnt    = '0;
                n_state  = i_status.div_sat ? S_LHS : S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.op = CMD_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_LHS;
                end
            end
            S_LHS: begin
                o_cmd.op = CMD_LHS;
                n_state  = S_PH;
            end
            S_PH: begin
                n_crs_done = 1'b0;
                unique case (r_phase)
                    PH_ACC: begin
                        o_cmd.op = CMD_ACC;
                        if (i_status.acc_lim) begin
                            n_phase = PH_CRUISE;
                        end
                        n_state = S_BMUL;
                    end
                    PH_CRUISE: n_state = S_CRS;
                    default:   n_state = S_DEC;
                endcase
            end
            S_CRS: begin
                o_cmd.op   = CMD_CRUISE;
                n_crs_done = 1'b1;
                n_state    = S_BMUL;
            end
            S_BMUL: begin
                o_cmd.op = CMD_BMUL;
                n_state  = S_BCMP;
            end
            S_BCMP: begin
                if (i_status.brake) begin
                    n_phase = PH_DECEL;
                    n_state = S_DEC;
                end else if (r_phase == PH_CRUISE && !r_crs_done) begin
                    n_state = S_CRS;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DEC: begin
                o_cmd.op = CMD_DEC;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = CMD_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ design/rsp_datapath.sv @@
// Arithmetic of the rotation speed profiler: registers, heading error, products,
// bit-serial stopping-angle divider, phase speed rules, output register. Depends on rsp_pkg.
module rsp_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsp_pkg::t_cmd       i_cmd,
    output rsp_pkg::t_status    o_status,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [30:0]         i_cfg_data,
    input  logic signed [18:0]  i_target_angle,
    input  logic signed [18:0]  i_robot_angle,
    input  logic signed [31:0]  i_robot_rot_speed,
    input  logic [16:0]         i_step_time,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_rot_speed_cmd,
    output logic                o_goal_reached,
    output logic [1:0]          o_phase
);
    import rsp_pkg::*;

    logic [30:0]        r_accel, r_speed, r_floor;
    logic [17:0]        r_tol;
    logic signed [18:0] r_target;
    logic               r_goal;
    logic               r_ovalid;

    logic signed [20:0] r_err;
    logic signed [31:0] r_v;
    logic [16:0]        r_dt;
    logic [62:0]        r_sq;
    logic [48:0]        r_dtv_mag;
    logic               r_dtv_neg;
    logic [31:0]        r_rem;
    logic [30:0]        r_lo;
    logic [30:0]        r_quo;
    logic signed [31:0] r_lhs;
    logic signed [31:0] r_r;
    logic [48:0]        r_rdt_mag;
    logic               r_rdt_neg;
    logic signed [31:0] r_orot;
    logic               r_ogoal;
    logic [1:0]         r_ophase;

    logic signed [20:0] err_raw, err_w;
    logic               err_neg;
    logic [31:0]        v_mag, r_mag, divisor;
    logic [63:0]        sq_full;
    logic [32:0]        div_t;
    logic               div_ge;
    logic signed [31:0] dtv_s, rdt_s, rem_s, acc_r, crs_r, dec_r, s_pos, s_neg;
    logic signed [33:0] v34, a34, f34, acc_sum, c_plus, c_minus, dec_sum;
    logic [32:0]        acc_mag, rem_mag;
    logic [20:0]        err_mag;
    logic               in_tol;

    always_comb begin
        err_raw = 21'(r_target) - 21'(i_robot_angle);
        if (err_raw > PI_Q) begin
            err_w = err_raw - TWO_PI_Q;
        end else if (err_raw < -PI_Q) begin
            err_w = err_raw + TWO_PI_Q;
        end else begin
            err_w = err_raw;
        end

        err_neg = r_err[20];
        err_mag = err_neg ? 21'(-r_err) : 21'(r_err);
        in_tol  = err_mag <= {3'b000, r_tol};

        v_mag   = r_v[31] ? (~r_v + 32'd1) : r_v;
        sq_full = 64'(v_mag) * 64'(v_mag);
        divisor = {r_accel, 1'b0};
        div_t   = {r_rem, r_lo[30]};
        div_ge  = div_t >= {1'b0, divisor};

        v34   = 34'(r_v);
        a34   = {3'b000, r_accel};
        f34   = {3'b000, r_floor};
        s_pos = {1'b0, r_speed};
        s_neg = -s_pos;

        acc_sum = err_neg ? (v34 - a34) : (v34 + a34);
        acc_mag = acc_sum[33] ? 33'(-acc_sum) : 33'(acc_sum);
        acc_r   = (acc_mag >= {2'b00, r_speed}) ? (acc_sum[33] ? s_neg : s_pos) : acc_sum[31:0];
        crs_r   = err_neg ? s_neg : s_pos;

        c_plus  = v34 + a34;
        c_minus = v34 - a34;
        if (err_neg) begin
            dec_sum = (-f34 < c_plus) ? -f34 : c_plus;
        end else begin
            dec_sum = (f34 > c_minus) ? f34 : c_minus;
        end
        dec_r = sat32(dec_sum);

        r_mag   = r_r[31] ? (~r_r + 32'd1) : r_r;
        dtv_s   = mag_to_s32(r_dtv_neg, r_dtv_mag[48:16]);
        rdt_s   = mag_to_s32(r_rdt_neg, r_rdt_mag[48:16]);
        rem_s   = sat32(34'(r_err) + 34'(rdt_s));
        rem_mag = rem_s[31] ? 33'(-34'(rem_s)) : 33'(rem_s);

        o_status.acc_lim  = acc_mag >= {2'b00, r_speed};
        o_status.div_sat  = (r_accel == '0) || (r_sq[62:31] >= divisor);
        o_status.brake    = !r_lhs[31] && ({1'b0, r_lhs} >= rem_mag);
        o_status.out_busy = r_ovalid && !i_out_ready;
    end

    // Control and configuration state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel  <= ACCEL_RST;
            r_speed  <= SPEED_RST;
            r_floor  <= FLOOR_RST;
            r_tol    <= TOL_RST;
            r_target <= '0;
            r_goal   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_ACCEL: r_accel <= i_cfg_data;
                    CFG_SPEED: r_speed <= i_cfg_data;
                    CFG_FLOOR: r_floor <= i_cfg_data;
                    CFG_TOL:   r_tol   <= i_cfg_data[17:0];
                    default:   r_tol   <= r_tol;
                endcase
            end
            if (i_cmd.op == CMD_SET_TARGET) begin
                r_target <= i_target_angle;
                r_goal   <= 1'b0;
            end
            if (i_cmd.op == CMD_DEC && in_tol) begin
                r_goal <= 1'b1;
            end
            if (i_cmd.op == CMD_OUT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working registers, loaded on command.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CMD_LOAD: begin
                r_err <= err_w;
                r_v   <= i_robot_rot_speed;
                r_dt  <= i_step_time;
            end
            CMD_MUL: begin
                r_sq      <= sq_full[62:0];
                r_dtv_mag <= 49'(v_mag) * 49'(r_dt);
                r_dtv_neg <= r_v[31];
            end
            CMD_DIV_INIT: begin
                r_rem <= r_sq[62:31];
                r_lo  <= r_sq[30:0];
                r_quo <= '1;
            end
            CMD_DIV_STEP: begin
                r_rem <= div_ge ? 32'(div_t - {1'b0, divisor}) : div_t[31:0];
                r_lo  <= {r_lo[29:0], 1'b0};
                r_quo <= {r_quo[29:0], div_ge};
            end
            CMD_LHS:    r_lhs <= sat32(34'({1'b0, r_quo}) + 34'(dtv_s));
            CMD_ACC:    r_r   <= acc_r;
            CMD_CRUISE: r_r   <= crs_r;
            CMD_BMUL: begin
                r_rdt_mag <= 49'(r_mag) * 49'(r_dt);
                r_rdt_neg <= r_r[31];
            end
            CMD_DEC:    r_r <= in_tol ? 32'sd0 : dec_r;
            CMD_OUT: begin
                // The goal flag is captured with the word, since a later
                // set-target may clear it while this word still waits.
                r_orot   <= r_r;
                r_ogoal  <= r_goal;
                r_ophase <= i_cmd.phase;
            end
            default: r_r <= r_r;
        endcase
    end

    assign o_out_valid     = r_ovalid;
    assign o_rot_speed_cmd = r_orot;
    assign o_goal_reached  = r_ogoal;
    assign o_phase         = r_ophase;

endmodule

@@ design/rotation_speed_profile_unit.sv @@
// Top level of the trapezoidal rotation speed profiler: stream ports, word
// packing, controller and datapath. Depends on rsp_pkg, rsp_ctrl, rsp_datapath.
//
// Channel   Direction  Accept when              Contents
// s_axis    in         tvalid && tready         one set-target or control-step word
// m_axis    out        tvalid && tready         one speed command word per control step
// cfg       in         i_cfg_wr_en high         register write, index 0..3
//
// A control step gets the stopping angle v*v/(2a) from a one-bit-per-cycle restoring
// divider of 31 steps, and a step that moves from accelerate into cruise runs the
// brake test twice unless the first test brakes. When the stopping angle saturates
// the divider is skipped. A set-target word produces no output word.
// Reset is synchronous and active low; it restores the register defaults, phase
// accelerate, target zero and a cleared goal flag. While the output word stalls,
// the next input word is still accepted and works up to the output register.
module rotation_speed_profile_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: target_angle[18:0], robot_angle[37:19], robot_rot_speed[69:38],
    // step_time[86:70], zero fill [87]
    input  logic [87:0]  s_axis_tdata,
    // tuser: action (0 set target, 1 control step)
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: rot_speed_cmd[31:0], goal_reached[32], phase[34:33], zero fill [39:35]
    output logic [39:0]  m_axis_tdata,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data
);
    import rsp_pkg::*;

    t_cmd               cmd;
    t_status            status;
    logic signed [31:0] rot_speed_cmd;
    logic               goal_reached;
    logic [1:0]         phase;

    rsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rsp_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_target_angle    ($signed(s_axis_tdata[18:0])),
        .i_robot_angle     ($signed(s_axis_tdata[37:19])),
        .i_robot_rot_speed ($signed(s_axis_tdata[69:38])),
        .i_step_time       (s_axis_tdata[86:70]),
        .o_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .o_rot_speed_cmd   (rot_speed_cmd),
        .o_goal_reached    (goal_reached),
        .o_phase           (phase)
    );

    assign m_axis_tdata = {5'b00000, phase, goal_reached, rot_speed_cmd};

endmodule
